FILE: rtl/adv_uuid_pkg.sv
// Package: request/result types and constants for the advertising UUID matcher.
package adv_uuid_pkg;

  localparam logic [7:0]  TYPE_UUID16_PARTIAL  = 8'h02;
  localparam logic [7:0]  TYPE_UUID16_COMPLETE = 8'h03;
  localparam logic [15:0] UUID_A_RESET         = 16'hFFE0;
  localparam logic [15:0] UUID_B_RESET         = 16'hFFF0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_UUID_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_UUID_B = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] payload_length;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic uuid_found;
    logic result_last;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] match_uuid_a;
    logic [15:0] match_uuid_b;
  } match_cfg_t;

endpackage

FILE: rtl/adv_uuid_parse.sv
// Per-payload parser state: walks length-type-data structures and matches UUIDs.
module adv_uuid_parse (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  adv_uuid_pkg::in_req_t   item_i,
  input  adv_uuid_pkg::match_cfg_t cfg_i,
  output logic                    found_o
);
  import adv_uuid_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] start_q, start_d;
  logic [7:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] low_q, low_d;
  logic       stop_q, stop_d;
  logic       match_q, match_d;

  logic       skip;
  logic [7:0] off_raw;
  logic [7:0] off;
  logic       new_struct;
  logic [8:0] end_pos;
  logic [15:0] uuid;
  logic       is_list;

  always_comb begin
    skip       = stop_q || (pos_q >= item_i.payload_length);
    off_raw    = pos_q - start_q;
    new_struct = ({1'b0, off_raw} == ({1'b0, len_q} + 9'd1));
    off        = new_struct ? 8'd0 : off_raw;
    end_pos    = {1'b0, pos_q} + {1'b0, item_i.data_byte};
    uuid       = {item_i.data_byte, low_q};
    is_list    = (type_q == TYPE_UUID16_PARTIAL) || (type_q == TYPE_UUID16_COMPLETE);

    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    type_d  = type_q;
    low_d   = low_q;
    stop_d  = stop_q;
    match_d = match_q;

    if (!skip) begin
      if (new_struct) start_d = pos_q;
      if (off == 8'd0) begin
        if (item_i.data_byte == 8'd0 || end_pos >= {1'b0, item_i.payload_length})
          stop_d = 1'b1;
        else
          len_d = item_i.data_byte;
      end else if (off == 8'd1) begin
        type_d = item_i.data_byte;
      end else if (is_list) begin
        if (!off[0]) begin
          low_d = item_i.data_byte;
        end else if (uuid == cfg_i.match_uuid_a || uuid == cfg_i.match_uuid_b) begin
          match_d = 1'b1;
        end
      end
    end
    if (pos_q != 8'hFF) pos_d = pos_q + 8'd1;
  end

  // result covers the byte being stepped now
  assign found_o = match_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      type_q  <= '0;
      low_q   <= '0;
      stop_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q   <= '0;
        start_q <= '0;
        len_q   <= '0;
        type_q  <= '0;
        low_q   <= '0;
        stop_q  <= 1'b0;
        match_q <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        type_q  <= type_d;
        low_q   <= low_d;
        stop_q  <= stop_d;
        match_q <= match_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> pos_q == 8'd0 && !match_q && !stop_q)
    else $error("parser state not cleared after last byte");

  a_start_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("structure start beyond byte position");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.last_byte && match_q |=> match_q)
    else $error("match flag dropped within a payload");

endmodule

FILE: rtl/adv_service_uuid_matcher_top.sv
// Top level: input register, parser, result register and config registers.
//
//  channel | direction | handshake              | payload
//  in      | request   | in_valid_i/in_stall_o  | in_req_i (data, length, last)
//  out     | result    | out_valid_o/out_stall_i| out_rsp_o (found, last)
//  cfg     | write     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request per cycle sustained while no final byte is stalled; a result is valid once its last byte
// has passed the input register and then the result register.
// Parser state is registered and updates from the registered request.
// Reset clears parser state and loads the UUID registers with their defaults.
// Out stall holds the result; the input register keeps taking non-final bytes meanwhile.
module adv_service_uuid_matcher_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  adv_uuid_pkg::in_req_t             in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output adv_uuid_pkg::out_rsp_t            out_rsp_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adv_uuid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import adv_uuid_pkg::*;

  logic       req_v_q;
  in_req_t    req_q;
  logic       rsp_v_q;
  out_rsp_t   rsp_q;
  match_cfg_t cfg_q;
  logic       proc;
  logic       can_proc;
  logic       found;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_uuid_a <= UUID_A_RESET;
      cfg_q.match_uuid_b <= UUID_B_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MATCH_UUID_A: cfg_q.match_uuid_a <= cfg_data_i;
        REG_MATCH_UUID_B: cfg_q.match_uuid_b <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a final byte needs room in the result register
  assign can_proc   = !req_q.last_byte || !rsp_v_q || !out_stall_i;
  assign proc       = req_v_q && can_proc;
  assign in_stall_o = req_v_q && !can_proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) req_q <= in_req_i;
  end

  adv_uuid_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (proc),
    .item_i  (req_q),
    .cfg_i   (cfg_q),
    .found_o (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
    end else if (proc && req_q.last_byte) begin
      rsp_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && req_q.last_byte) begin
      rsp_q.uuid_found  <= found;
      rsp_q.result_last <= 1'b1;
    end
  end

  assign out_valid_o = rsp_v_q;
  assign out_rsp_o   = rsp_q;

  a_stall_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_v_q && req_q.last_byte && rsp_v_q)
    else $error("input stalled without a blocked final byte");

  a_rsp_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(proc && req_q.last_byte))
    else $error("result without a final byte");

  a_rsp_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.result_last)
    else $error("result not marked last");

endmodule

FILE: bench/adv_service_uuid_matcher_top_tb.sv
// Testbench for the advertising UUID matcher: directed and random payloads vs a predictor.
module adv_service_uuid_matcher_top_tb;
  import adv_uuid_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;
  localparam int SHOWN_ERRORS = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_rsp_t             out_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MATCH_UUID_A;
  logic [15:0]          cfg_data = '0;

  adv_service_uuid_matcher_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor copy of the registers and the per-payload parse state
  match_cfg_t match_cfg = '{match_uuid_a: UUID_A_RESET, match_uuid_b: UUID_B_RESET};
  logic [7:0] scan_pos, ad_start, ad_len, ad_type, uuid_lo;
  logic       scan_stopped, uuid_hit;

  out_rsp_t   pending_verdicts[$];
  logic [7:0] pay_data[$];
  logic [7:0] pay_plen[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int bad_results   = 0;
  int cycle_cnt     = 0;

  function automatic void clear_scan();
    scan_pos     = '0;
    ad_start     = '0;
    ad_len       = '0;
    ad_type      = '0;
    uuid_lo      = '0;
    scan_stopped = 1'b0;
    uuid_hit     = 1'b0;
  endfunction

  // one accepted request: advance the parse, queue a verdict on the last byte
  function automatic void scan_adv_byte(input in_req_t r);
    int unsigned off;
    logic [15:0] uuid;
    out_rsp_t    verdict;
    if (!scan_stopped && scan_pos < r.payload_length) begin
      off = int'(scan_pos) - int'(ad_start);
      if (off == int'(ad_len) + 1) begin
        ad_start = scan_pos;
        off = 0;
      end
      if (off == 0) begin
        if (r.data_byte == 8'd0 || int'(scan_pos) + int'(r.data_byte) >= int'(r.payload_length))
          scan_stopped = 1'b1;
        else
          ad_len = r.data_byte;
      end else if (off == 1) begin
        ad_type = r.data_byte;
      end else if (ad_type == TYPE_UUID16_PARTIAL || ad_type == TYPE_UUID16_COMPLETE) begin
        if (off[0] == 1'b0) begin
          uuid_lo = r.data_byte;
        end else begin
          uuid = {r.data_byte, uuid_lo};
          if (uuid == match_cfg.match_uuid_a || uuid == match_cfg.match_uuid_b)
            uuid_hit = 1'b1;
        end
      end
    end
    if (scan_pos != 8'hFF) scan_pos = scan_pos + 8'd1;
    if (r.last_byte) begin
      verdict.uuid_found  = uuid_hit;
      verdict.result_last = 1'b1;
      pending_verdicts.insert(pending_verdicts.size(), verdict);
      clear_scan();
    end
  endfunction

  // entered and left at a falling edge; valid stays high for a back-to-back request
  task automatic send_byte(input in_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    scan_adv_byte(r);
    @(negedge clk);
  endtask

  task automatic send_payload();
    in_req_t r;
    for (int i = 0; i < pay_data.size(); i++) begin
      r.data_byte      = pay_data[i];
      r.payload_length = pay_plen[i];
      r.last_byte      = (i == pay_data.size() - 1);
      send_byte(r);
    end
  endtask

  task automatic send_bytes_at(input logic [7:0] plen);
    pay_plen.delete();
    foreach (pay_data[i]) pay_plen.insert(pay_plen.size(), plen);
    send_payload();
  endtask

  // idle the request side and let every verdict come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic load_matches(input logic [15:0] uuid_a, input logic [15:0] uuid_b);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MATCH_UUID_A;
    cfg_data  <= uuid_a;
    do @(posedge clk); while (!cfg_ready);
    match_cfg.match_uuid_a = uuid_a;
    @(negedge clk);
    cfg_index <= REG_MATCH_UUID_B;
    cfg_data  <= uuid_b;
    do @(posedge clk); while (!cfg_ready);
    match_cfg.match_uuid_b = uuid_b;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // well-formed structure list, then maybe broken: short/long length, zero length,
  // early last, trailing bytes, a length that changes mid-payload
  task automatic build_adv_payload();
    int          len, n_uuid, cut;
    logic [7:0]  plen, kind;
    logic [15:0] uuid;
    pay_data.delete();
    pay_plen.delete();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(9) < 7)
        kind = $urandom_range(1) ? TYPE_UUID16_COMPLETE : TYPE_UUID16_PARTIAL;
      else
        kind = 8'($urandom_range(255));
      n_uuid = int'($urandom_range(0, 4));
      len = 1 + 2 * n_uuid + int'($urandom_range(3) == 0);
      pay_data.insert(pay_data.size(), len[7:0]);
      pay_data.insert(pay_data.size(), kind);
      repeat (n_uuid) begin
        case ($urandom_range(9))
          0, 1, 2: uuid = match_cfg.match_uuid_a;
          3, 4:    uuid = match_cfg.match_uuid_b;
          5:       uuid = match_cfg.match_uuid_a ^ (16'd1 << $urandom_range(15));
          default: uuid = 16'($urandom_range(16'hFFFF));
        endcase
        pay_data.insert(pay_data.size(), uuid[7:0]);
        pay_data.insert(pay_data.size(), uuid[15:8]);
      end
      if (len % 2 == 0) pay_data.insert(pay_data.size(), 8'($urandom_range(255)));
    end
    plen = 8'(pay_data.size());
    case ($urandom_range(11))
      0: plen = plen + 8'($urandom_range(1, 6));
      1: plen = 8'($urandom_range(1, plen));
      2: begin
        pay_data.insert(pay_data.size(), 8'h00);
        repeat ($urandom_range(1, 4))
          pay_data.insert(pay_data.size(), 8'($urandom_range(255)));
        plen = 8'(pay_data.size());
      end
      3: begin
        cut = int'($urandom_range(1, pay_data.size()));
        while (pay_data.size() > cut) void'(pay_data.pop_back());
      end
      4: repeat ($urandom_range(1, 5))
           pay_data.insert(pay_data.size(), 8'($urandom_range(255)));
      default: ;
    endcase
    foreach (pay_data[i]) pay_plen.insert(pay_plen.size(), plen);
    if ($urandom_range(7) == 0)
      pay_plen[$urandom_range(pay_plen.size() - 1)] = 8'($urandom_range(1, 255));
  endtask

  task automatic run_random_payloads(input int n_bytes);
    int sent;
    logic [7:0] plen;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(7) == 0) begin
        pay_data.delete();
        pay_plen.delete();
        plen = 8'($urandom_range(255));
        repeat ($urandom_range(1, 8)) begin
          pay_data.insert(pay_data.size(), 8'($urandom_range(255)));
          pay_plen.insert(pay_plen.size(), plen);
        end
      end else begin
        build_adv_payload();
      end
      send_payload();
      sent += pay_data.size();
    end
  endtask

  // reset UUIDs, one payload per special case
  task automatic test_reset_defaults();
    pay_data = '{8'h03, TYPE_UUID16_COMPLETE, UUID_A_RESET[7:0], UUID_A_RESET[15:8]};
    send_bytes_at(8'd4);   // match completed by the last byte
    pay_data = '{8'h02, 8'h01, 8'h06, 8'h04, TYPE_UUID16_PARTIAL,
                 UUID_B_RESET[7:0], UUID_B_RESET[15:8], 8'hAA};
    send_bytes_at(8'd8);   // second UUID, lone trailing byte
    pay_data = '{8'h00, TYPE_UUID16_COMPLETE};
    send_bytes_at(8'd255); // zero length byte stops parsing
    pay_data = '{8'h04, TYPE_UUID16_COMPLETE, UUID_A_RESET[7:0], UUID_A_RESET[15:8]};
    send_bytes_at(8'd4);   // structure ends exactly at the payload length
    pay_data = '{8'h03, TYPE_UUID16_COMPLETE, UUID_A_RESET[7:0]};
    send_bytes_at(8'd4);   // last mark arrives early
    pay_data = '{8'h03};
    send_bytes_at(8'd0);   // zero payload length
    pay_data = '{8'h01, 8'hFF, 8'h03};
    send_bytes_at(8'd2);   // byte beyond the length
    drain();
  endtask

  task automatic test_match_settings();
    logic [15:0] u;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  load_matches(16'h0000, 16'hFFFF); end
        1: begin send_idle_pct = 51; stall_pct = 0;  load_matches(16'hFFFF, 16'h0000); end
        2: begin
          send_idle_pct = 0;
          stall_pct = 51;
          load_matches(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
          u = 16'($urandom_range(16'hFFFF));
          load_matches(u, u);
        end
      endcase
      run_random_payloads(190);
      drain();
    end
  endtask

  // payload longer than 255 bytes: the position must saturate, not wrap
  task automatic test_position_saturation();
    logic [15:0] miss;
    miss = match_cfg.match_uuid_a ^ 16'h0001;
    if (miss == match_cfg.match_uuid_b) miss = match_cfg.match_uuid_a ^ 16'h0002;
    pay_data.delete();
    repeat (25) begin
      pay_data.insert(pay_data.size(), 8'd9);
      pay_data.insert(pay_data.size(), 8'hFF);
      repeat (8) pay_data.insert(pay_data.size(), 8'($urandom_range(255)));
    end
    // last structure ends at 254, its UUID list still open
    pay_data.insert(pay_data.size(), 8'd4);
    pay_data.insert(pay_data.size(), TYPE_UUID16_COMPLETE);
    pay_data.insert(pay_data.size(), miss[7:0]);
    pay_data.insert(pay_data.size(), miss[15:8]);
    pay_data.insert(pay_data.size(), 8'h5A);
    pay_data.insert(pay_data.size(), 8'hA5);
    // these would complete a matching UUID if the position wrapped
    repeat (4) begin
      pay_data.insert(pay_data.size(), match_cfg.match_uuid_a[7:0]);
      pay_data.insert(pay_data.size(), match_cfg.match_uuid_a[15:8]);
    end
    send_bytes_at(8'd255);
    drain();
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : check_verdicts
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        bad_results++;
        if (bad_results <= SHOWN_ERRORS)
          $display("unexpected verdict found=%b last=%b at cycle %0d",
                   out_rsp.uuid_found, out_rsp.result_last, cycle_cnt);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_rsp.uuid_found !== want.uuid_found || out_rsp.result_last !== want.result_last) begin
          bad_results++;
          if (bad_results <= SHOWN_ERRORS)
            $display("verdict mismatch at cycle %0d: expected found=%b last=%b, got found=%b last=%b",
                     cycle_cnt, want.uuid_found, want.result_last,
                     out_rsp.uuid_found, out_rsp.result_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_scan();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_match_settings();
    send_idle_pct = 24;
    stall_pct = 24;
    test_position_saturation();
    if (pending_verdicts.size() != 0)
      $display("%0d verdicts never arrived", pending_verdicts.size());
    if (bad_results == 0 && pending_verdicts.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
